>>> rtl/cvdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cvdf_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int unsigned FRAC_DIGITS = 2;

  // decimal digits of 2**w - 1 (1233 / 4096 ~ log10 2)
  function automatic int unsigned dec_digits(input int unsigned w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_SHIFT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_BITS,
    C_SKIP,
    C_INT
  } cond_t;

  typedef enum logic {
    SRC_CONST,
    SRC_DIGIT
  } src_t;

  typedef struct packed {
    logic       emit;
    logic       last;
    src_t       src;
    logic [7:0] ch;
    op_t        op;
    cond_t      cond;
    step_t      target;
  } ctrl_t;

  typedef struct packed {
    op_t  op;
    logic en;
  } dp_cmd_t;

  typedef struct packed {
    logic       bits_more;
    logic       skip_go;
    logic       int_more;
    logic [3:0] top_digit;
  } dp_stat_t;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_CONV = 4'd1;
  localparam step_t S_SKIP = 4'd8;
  localparam step_t S_INT  = 4'd9;
  localparam int unsigned NUM_STEPS = 16;

  function automatic ctrl_t cw_char(input logic [7:0] ch, input logic last,
                                    input cond_t cond);
    ctrl_t c;
    c = '{emit: 1'b1, last: last, src: SRC_CONST, ch: ch, op: OP_NONE,
          cond: cond, target: S_IDLE};
    return c;
  endfunction

  function automatic ctrl_t cw_digit(input op_t op, input cond_t cond,
                                     input step_t target);
    ctrl_t c;
    c = '{emit: 1'b1, last: 1'b0, src: SRC_DIGIT, ch: CH_NUL, op: op,
          cond: cond, target: target};
    return c;
  endfunction

  function automatic ctrl_t cw_op(input op_t op, input cond_t cond,
                                  input step_t target);
    ctrl_t c;
    c = '{emit: 1'b0, last: 1'b0, src: SRC_CONST, ch: CH_NUL, op: op,
          cond: cond, target: target};
    return c;
  endfunction

  localparam ctrl_t PROGRAM [NUM_STEPS] = '{
    cw_op(OP_LOAD, C_NO_IN, S_IDLE),
    cw_op(OP_DABBLE, C_BITS, S_CONV),
    cw_char(CH_L, 1'b0, C_NEXT),
    cw_char(CH_U, 1'b0, C_NEXT),
    cw_char(CH_X, 1'b0, C_NEXT),
    cw_char(CH_SPACE, 1'b0, C_NEXT),
    cw_char(CH_EQ, 1'b0, C_NEXT),
    cw_char(CH_SPACE, 1'b0, C_NEXT),
    cw_op(OP_SKIP, C_SKIP, S_SKIP),
    cw_digit(OP_SHIFT, C_INT, S_INT),
    cw_char(CH_DOT, 1'b0, C_NEXT),
    cw_digit(OP_SHIFT, C_NEXT, S_IDLE),
    cw_digit(OP_SHIFT, C_NEXT, S_IDLE),
    cw_char(CH_CR, 1'b0, C_NEXT),
    cw_char(CH_LF, 1'b1, C_ALWAYS),
    cw_op(OP_NONE, C_ALWAYS, S_IDLE)
  };

endpackage
`default_nettype wire

>>> rtl/cvdf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cvdf_in_if #(
  parameter int unsigned VALUE_WIDTH = cvdf_pkg::VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] hundredths_value;

  modport source (output valid, output hundredths_value, input ready);
  modport sink (input valid, input hundredths_value, output ready);
endinterface

interface cvdf_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface
`default_nettype wire

>>> rtl/cvdf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module cvdf_datapath #(
  parameter int unsigned VALUE_WIDTH = cvdf_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DIGITS      = cvdf_pkg::dec_digits(VALUE_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire cvdf_pkg::dp_cmd_t      cmd,
  output cvdf_pkg::dp_stat_t          stat
);

  // two bits per dabble step; odd widths get a leading zero
  localparam int unsigned PW    = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int unsigned STEPS = PW / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);
  localparam int unsigned NW    = $clog2(DIGITS);
  localparam int unsigned BW    = 4 * DIGITS;

  logic [PW-1:0] bin_r;
  logic [BW-1:0] bcd_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] nint_r;

  logic [BW-1:0] adj0, adj1, bcd1, bcd2;
  logic [PW-1:0] bin1, bin2;

  function automatic logic [BW-1:0] add3(input logic [BW-1:0] b);
    logic [BW-1:0] r;
    r = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    adj0         = add3(bcd_r);
    {bcd1, bin1} = {adj0, bin_r} << 1;
    adj1         = add3(bcd1);
    {bcd2, bin2} = {adj1, bin1} << 1;
  end

  always_comb begin
    stat.top_digit = bcd_r[BW-1 -: 4];
    stat.bits_more = cnt_r > CW'(1);
    stat.int_more  = nint_r > NW'(1);
    stat.skip_go   = (nint_r > NW'(1)) && (bcd_r[BW-1 -: 4] == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      unique case (cmd.op)
        cvdf_pkg::OP_LOAD: begin
          bin_r  <= PW'(value);
          bcd_r  <= '0;
          cnt_r  <= CW'(STEPS);
          nint_r <= NW'(DIGITS - cvdf_pkg::FRAC_DIGITS);
        end
        cvdf_pkg::OP_DABBLE: begin
          bin_r <= bin2;
          bcd_r <= bcd2;
          cnt_r <= cnt_r - CW'(1);
        end
        cvdf_pkg::OP_SKIP: begin
          if (stat.skip_go) begin
            bcd_r  <= bcd_r << 4;
            nint_r <= nint_r - NW'(1);
          end
        end
        cvdf_pkg::OP_SHIFT: begin
          bcd_r  <= bcd_r << 4;
          nint_r <= nint_r - NW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/cvdf_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
module cvdf_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last,
  output cvdf_pkg::dp_cmd_t       cmd,
  input  wire cvdf_pkg::dp_stat_t stat
);

  cvdf_pkg::step_t step_r, step_nxt;
  cvdf_pkg::ctrl_t ctrl;
  logic            out_valid_r;
  logic [7:0]      char_r, char_nxt;
  logic            last_r;
  logic            out_free, stall, take;

  always_comb begin
    ctrl     = cvdf_pkg::PROGRAM[step_r];
    out_free = !out_valid_r || out_ready;
    stall    = ctrl.emit && !out_free;
    unique case (ctrl.cond)
      cvdf_pkg::C_NEXT:   take = 1'b0;
      cvdf_pkg::C_ALWAYS: take = 1'b1;
      cvdf_pkg::C_NO_IN:  take = !in_valid;
      cvdf_pkg::C_BITS:   take = stat.bits_more;
      cvdf_pkg::C_SKIP:   take = stat.skip_go;
      cvdf_pkg::C_INT:    take = stat.int_more;
      default:            take = 1'b1;
    endcase
    if (stall) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + cvdf_pkg::step_t'(1);
    end
    char_nxt = (ctrl.src == cvdf_pkg::SRC_DIGIT) ?
               (cvdf_pkg::CH_ZERO | {4'h0, stat.top_digit}) : ctrl.ch;
    in_ready = ctrl.op == cvdf_pkg::OP_LOAD;
    cmd.op   = ctrl.op;
    cmd.en   = !stall && ((ctrl.op != cvdf_pkg::OP_LOAD) || in_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= cvdf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (ctrl.emit && out_free) begin
        out_valid_r <= 1'b1;
        char_r      <= char_nxt;
        last_r      <= ctrl.last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

>>> rtl/centi_value_decimal_formatter_unit.sv
// Centi-value decimal formatter.
// in_ch (valid/ready): one beat carries hundredths_value, an unsigned count of
// hundredths. out_ch (valid/ready): one beat per ASCII character of the line
// "lux = <integer>.<two digits>" CR LF; last_char is set on the LF beat.
// The integer part has no leading zeros, or is a single '0'.
// Each value is converted to BCD by double dabble, two bits per cycle, then a
// microcode program of 16 steps emits the characters, at most one per cycle.
// in_ch is ready only on the idle step; one value is worked on at a time,
// and the next can be taken while the final LF still waits in the output
// register. A stalled receiver holds the output beat and freezes the program
// at its next emitting step. Reset returns the program to idle and drops
// out_ch valid.
`timescale 1ns / 1ps
`default_nettype none
module centi_value_decimal_formatter_unit #(
  parameter int unsigned VALUE_WIDTH = cvdf_pkg::VALUE_WIDTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  cvdf_in_if.sink     in_ch,
  cvdf_out_if.source  out_ch
);

  localparam int unsigned DIGITS = cvdf_pkg::dec_digits(VALUE_WIDTH);

  cvdf_pkg::dp_cmd_t  cmd;
  cvdf_pkg::dp_stat_t stat;

  cvdf_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.ascii_char),
    .out_last  (out_ch.last_char),
    .cmd       (cmd),
    .stat      (stat)
  );

  cvdf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_dp (
    .clk   (clk),
    .value (in_ch.hundredths_value),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule
`default_nettype wire
